// File: hw/rtl/rmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rmt_pkg;

  typedef logic signed [31:0] fix32_t;

  // pipeline shape
  localparam int NSTAGE   = 49;  // registered stages before the output register
  localparam int DIV_BITS = 33;  // quotient bits, one per divider bit stage
  localparam int DIV_LAT  = 36;  // stages inside the divider unit

  // multiplier: unsigned, split in two halves per operand
  localparam int MUL_W  = 66;
  localparam int MUL_H  = 33;
  localparam int PROD_W = 2 * MUL_W;

  localparam int LIM_W = 61;   // parallel limit, units of 2^-60
  localparam int T_W   = 100;  // numerator, Q.76 signed
  localparam int DV_W  = 62;   // divisor 2*D
  localparam int REM_W = 95;   // divider remainder

  localparam logic [LIM_W-1:0] LIMIT_RESET = 61'd1152921505;
  localparam longint           ONE_Q60     = 64'sd1152921504606846976;
  localparam logic [61:0]      TWO_Q61     = 62'h2000_0000_0000_0000;
  localparam fix32_t           DIR_ONE     = 32'sd1073741824;
  localparam fix32_t           SAT_MAX     = 32'sh7FFF_FFFF;
  localparam fix32_t           SAT_MIN     = 32'sh8000_0000;

  function automatic fix32_t clamp_dir(input fix32_t d);
    fix32_t r;
    r = d;
    if (d > DIR_ONE) r = DIR_ONE;
    if (d < -DIR_ONE) r = -DIR_ONE;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ray_midpoint_triangulation.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | handshake              | payload
// ---------+------------------------+---------------------------------------------
// in       | in_valid / in_ready    | first/second origin xyz (Q15.16), dir xyz (Q1.30)
// out      | out_valid / out_ready  | point_x/y/z (Q15.16, saturated), point_valid
// config   | cfg_we                 | cfg_wdata: parallel limit, units of 2^-60
//
// One beat in per cycle while in_ready is high.
// Most of the pipe is the restoring divider: 33 stages, one quotient bit each,
// behind 13 stages of dot products and split 66x66 multipliers.
// rst clears all valid bits and loads the parallel limit with its reset value.
// A one-beat skid stage behind the output register absorbs a stall; in_ready
// drops only when the skid holds a beat, and then the whole pipe holds still.
module ray_midpoint_triangulation (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  rmt_pkg::fix32_t              first_origin_x,
  input  rmt_pkg::fix32_t              first_origin_y,
  input  rmt_pkg::fix32_t              first_origin_z,
  input  rmt_pkg::fix32_t              first_dir_x,
  input  rmt_pkg::fix32_t              first_dir_y,
  input  rmt_pkg::fix32_t              first_dir_z,
  input  rmt_pkg::fix32_t              second_origin_x,
  input  rmt_pkg::fix32_t              second_origin_y,
  input  rmt_pkg::fix32_t              second_origin_z,
  input  rmt_pkg::fix32_t              second_dir_x,
  input  rmt_pkg::fix32_t              second_dir_y,
  input  rmt_pkg::fix32_t              second_dir_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output rmt_pkg::fix32_t              point_x,
  output rmt_pkg::fix32_t              point_y,
  output rmt_pkg::fix32_t              point_z,
  output logic                         point_valid,
  input  logic                         cfg_we,
  input  logic [rmt_pkg::LIM_W-1:0]    cfg_wdata
);

  // parallel limit register
  logic [rmt_pkg::LIM_W-1:0] parallel_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      parallel_limit <= rmt_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      parallel_limit <= cfg_wdata;
    end
  end

  // global advance: the pipe moves whenever the skid stage is empty
  logic                       skid_valid;
  logic                       en;
  logic [rmt_pkg::NSTAGE-1:0] v;

  assign en       = !skid_valid;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[rmt_pkg::NSTAGE-2:0], in_valid};
    end
  end

  // arithmetic
  rmt_pkg::fix32_t oa [3], da [3], ob [3], db [3];

  assign oa[0] = first_origin_x;
  assign oa[1] = first_origin_y;
  assign oa[2] = first_origin_z;
  assign da[0] = first_dir_x;
  assign da[1] = first_dir_y;
  assign da[2] = first_dir_z;
  assign ob[0] = second_origin_x;
  assign ob[1] = second_origin_y;
  assign ob[2] = second_origin_z;
  assign db[0] = second_dir_x;
  assign db[1] = second_dir_y;
  assign db[2] = second_dir_z;

  logic signed [rmt_pkg::T_W-1:0] t [3];
  logic [rmt_pkg::DV_W-1:0]       dbl;
  logic                           par;

  rmt_geom u_geom (
    .clk      (clk),
    .en       (en),
    .origin_a (oa),
    .dir_a    (da),
    .origin_b (ob),
    .dir_b    (db),
    .limit    (parallel_limit),
    .t        (t),
    .dbl      (dbl),
    .par      (par)
  );

  // parallel flag rides alongside the divider
  logic [rmt_pkg::DIV_LAT-1:0] par_sh;

  always_ff @(posedge clk) begin
    if (en) begin
      par_sh <= {par_sh[rmt_pkg::DIV_LAT-2:0], par};
    end
  end

  rmt_pkg::fix32_t pt [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    rmt_div u_div (
      .clk   (clk),
      .en    (en),
      .t     (t[i]),
      .dv    (dbl),
      .point (pt[i])
    );
  end

  // beat leaving the pipe; parallel rays give a zero point
  logic            pipe_par;
  rmt_pkg::fix32_t px, py, pz;

  assign pipe_par = par_sh[rmt_pkg::DIV_LAT-1];
  assign px = pipe_par ? '0 : pt[0];
  assign py = pipe_par ? '0 : pt[1];
  assign pz = pipe_par ? '0 : pt[2];

  // output register plus skid
  rmt_pkg::fix32_t skid_x, skid_y, skid_z;
  logic            skid_pv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (v[rmt_pkg::NSTAGE-1]) begin
      if (!out_valid || out_ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        point_x     <= skid_x;
        point_y     <= skid_y;
        point_z     <= skid_z;
        point_valid <= skid_pv;
      end
    end else if (v[rmt_pkg::NSTAGE-1]) begin
      if (!out_valid || out_ready) begin
        point_x     <= px;
        point_y     <= py;
        point_z     <= pz;
        point_valid <= !pipe_par;
      end else begin
        skid_x  <= px;
        skid_y  <= py;
        skid_z  <= pz;
        skid_pv <= !pipe_par;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rmt_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// two-stage unsigned multiplier: four half-width partials, then one sum
module rmt_mul (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rmt_pkg::MUL_W-1:0]  x,
  input  logic [rmt_pkg::MUL_W-1:0]  y,
  output logic [rmt_pkg::PROD_W-1:0] prod
);

  logic [rmt_pkg::MUL_W-1:0] pp00, pp01, pp10, pp11;

  always_ff @(posedge clk) begin
    if (en) begin
      pp00 <= x[rmt_pkg::MUL_H-1:0] * y[rmt_pkg::MUL_H-1:0];
      pp01 <= x[rmt_pkg::MUL_H-1:0] * y[rmt_pkg::MUL_W-1:rmt_pkg::MUL_H];
      pp10 <= x[rmt_pkg::MUL_W-1:rmt_pkg::MUL_H] * y[rmt_pkg::MUL_H-1:0];
      pp11 <= x[rmt_pkg::MUL_W-1:rmt_pkg::MUL_H] * y[rmt_pkg::MUL_W-1:rmt_pkg::MUL_H];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= rmt_pkg::PROD_W'(pp00)
            + (rmt_pkg::PROD_W'(pp01) << rmt_pkg::MUL_H)
            + (rmt_pkg::PROD_W'(pp10) << rmt_pkg::MUL_H)
            + (rmt_pkg::PROD_W'(pp11) << rmt_pkg::MUL_W);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rmt_geom.sv
`timescale 1ns / 1ps
`default_nettype none

// dot products, denominator, numerators and the per-axis dividend T
module rmt_geom (
  input  logic                         clk,
  input  logic                         en,
  input  rmt_pkg::fix32_t              origin_a [3],
  input  rmt_pkg::fix32_t              dir_a    [3],
  input  rmt_pkg::fix32_t              origin_b [3],
  input  rmt_pkg::fix32_t              dir_b    [3],
  input  logic [rmt_pkg::LIM_W-1:0]    limit,
  output logic signed [rmt_pkg::T_W-1:0] t [3],
  output logic [rmt_pkg::DV_W-1:0]     dbl,
  output logic                         par
);

  // k0: clamp, difference and sum of origins
  logic signed [31:0] a0 [3], e0 [3];
  logic signed [32:0] b0 [3], m0 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a0[i] <= rmt_pkg::clamp_dir(dir_a[i]);
        e0[i] <= rmt_pkg::clamp_dir(dir_b[i]);
        b0[i] <= 33'(origin_b[i]) - 33'(origin_a[i]);
        m0[i] <= 33'(origin_b[i]) + 33'(origin_a[i]);
      end
    end
  end

  // k1: products
  logic signed [63:0] ae_c [3];
  logic signed [64:0] ba_c [3], be_c [3];
  logic signed [61:0] ae1 [3];
  logic signed [64:0] ba1 [3], be1 [3];
  logic signed [31:0] a1 [3], e1 [3];
  logic signed [32:0] m1 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ae_c[i] = a0[i] * e0[i];
      ba_c[i] = b0[i] * a0[i];
      be_c[i] = b0[i] * e0[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ae1[i] <= ae_c[i][61:0];
        ba1[i] <= ba_c[i];
        be1[i] <= be_c[i];
        a1[i]  <= a0[i];
        e1[i]  <= e0[i];
        m1[i]  <= m0[i];
      end
    end
  end

  // k2: c saturated to +-1, p and q
  logic signed [63:0] csum;
  logic signed [65:0] psum, qsum;
  logic signed [61:0] c2;
  logic signed [65:0] p2, q2;
  logic signed [31:0] a2 [3], e2 [3];
  logic signed [32:0] m2 [3];

  assign csum = ae1[0] + ae1[1] + ae1[2];
  assign psum = ba1[0] + ba1[1] + ba1[2];
  assign qsum = be1[0] + be1[1] + be1[2];

  always_ff @(posedge clk) begin
    if (en) begin
      if (csum > rmt_pkg::ONE_Q60) begin
        c2 <= 62'(rmt_pkg::ONE_Q60);
      end else if (csum < -rmt_pkg::ONE_Q60) begin
        c2 <= -62'(rmt_pkg::ONE_Q60);
      end else begin
        c2 <= csum[61:0];
      end
      p2 <= psum;
      q2 <= qsum;
      for (int i = 0; i < 3; i++) begin
        a2[i] <= a1[i];
        e2[i] <= e1[i];
        m2[i] <= m1[i];
      end
    end
  end

  // k3: magnitudes for the wide multipliers, u = 1 - |c|
  logic [60:0] cmag_c;
  logic [60:0] u3, cm3;
  logic [63:0] pm3, qm3;
  logic        cn3, pn3, qn3;
  logic signed [65:0] p3, q3;
  logic signed [31:0] a3 [3], e3 [3];
  logic signed [32:0] m3 [3];
  logic [61:0] w_c;

  assign cmag_c = c2[61] ? 61'(-c2) : 61'(c2);
  assign w_c    = rmt_pkg::TWO_Q61 - 62'(u3);

  always_ff @(posedge clk) begin
    if (en) begin
      u3  <= 61'(rmt_pkg::ONE_Q60) - cmag_c;
      cm3 <= cmag_c;
      cn3 <= c2[61];
      pm3 <= p2[65] ? 64'(-p2) : 64'(p2);
      pn3 <= p2[65];
      qm3 <= q2[65] ? 64'(-q2) : 64'(q2);
      qn3 <= q2[65];
      p3  <= p2;
      q3  <= q2;
      for (int i = 0; i < 3; i++) begin
        a3[i] <= a2[i];
        e3[i] <= e2[i];
        m3[i] <= m2[i];
      end
    end
  end

  // k4, k5: denominator product, c*q and c*p
  logic [rmt_pkg::PROD_W-1:0] prod_d, prod_cq, prod_cp;

  rmt_mul u_mul_d (
    .clk (clk), .en (en),
    .x (rmt_pkg::MUL_W'(u3)), .y (rmt_pkg::MUL_W'(w_c)), .prod (prod_d)
  );
  rmt_mul u_mul_cq (
    .clk (clk), .en (en),
    .x (rmt_pkg::MUL_W'(cm3)), .y (rmt_pkg::MUL_W'(qm3)), .prod (prod_cq)
  );
  rmt_mul u_mul_cp (
    .clk (clk), .en (en),
    .x (rmt_pkg::MUL_W'(cm3)), .y (rmt_pkg::MUL_W'(pm3)), .prod (prod_cp)
  );

  logic signed [65:0] p4, q4, p5, q5;
  logic               sq4, sp4, sq5, sp5;
  logic signed [31:0] a4 [3], e4 [3], a5 [3], e5 [3];
  logic signed [32:0] m4 [3], m5 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      p4  <= p3;
      q4  <= q3;
      sq4 <= cn3 ^ qn3;
      sp4 <= cn3 ^ pn3;
      p5  <= p4;
      q5  <= q4;
      sq5 <= sq4;
      sp5 <= sp4;
      for (int i = 0; i < 3; i++) begin
        a4[i] <= a3[i];
        e4[i] <= e3[i];
        m4[i] <= m3[i];
        a5[i] <= a4[i];
        e5[i] <= e4[i];
        m5[i] <= m4[i];
      end
    end
  end

  // k6: D, and c*q, c*p rounded from Q.106 to Q.46
  logic [rmt_pkg::PROD_W-1:0] rq_c, rp_c;
  logic [60:0]        d6;
  logic signed [66:0] prq6, prp6;
  logic signed [65:0] p6, q6;
  logic signed [31:0] a6 [3], e6 [3];
  logic signed [32:0] m6 [3];

  assign rq_c = prod_cq + (rmt_pkg::PROD_W'(1) << 59);
  assign rp_c = prod_cp + (rmt_pkg::PROD_W'(1) << 59);

  always_ff @(posedge clk) begin
    if (en) begin
      d6   <= prod_d[120:60];
      prq6 <= sq5 ? -$signed({1'b0, rq_c[125:60]}) : $signed({1'b0, rq_c[125:60]});
      prp6 <= sp5 ? -$signed({1'b0, rp_c[125:60]}) : $signed({1'b0, rp_c[125:60]});
      p6   <= p5;
      q6   <= q5;
      for (int i = 0; i < 3; i++) begin
        a6[i] <= a5[i];
        e6[i] <= e5[i];
        m6[i] <= m5[i];
      end
    end
  end

  // k7: numerators and the parallel test
  logic signed [66:0] na7, nb7;
  logic [60:0]        d7;
  logic               par7;
  logic signed [31:0] a7 [3], e7 [3];
  logic signed [32:0] m7 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      na7  <= 67'(p6) - prq6;
      nb7  <= prp6 - 67'(q6);
      par7 <= (d6 == '0) || (d6 < limit);
      d7   <= d6;
      for (int i = 0; i < 3; i++) begin
        a7[i] <= a6[i];
        e7[i] <= e6[i];
        m7[i] <= m6[i];
      end
    end
  end

  // k8: magnitudes and product signs for the second multiplier bank
  logic [65:0] nam8, nbm8;
  logic [30:0] am8 [3], em8 [3];
  logic [32:0] mm8 [3];
  logic        sa8 [3], se8 [3], sm8 [3];
  logic [60:0] d8;
  logic        par8;

  always_ff @(posedge clk) begin
    if (en) begin
      nam8 <= na7[66] ? 66'(-na7) : 66'(na7);
      nbm8 <= nb7[66] ? 66'(-nb7) : 66'(nb7);
      d8   <= d7;
      par8 <= par7;
      for (int i = 0; i < 3; i++) begin
        am8[i] <= a7[i][31] ? 31'(-a7[i]) : 31'(a7[i]);
        em8[i] <= e7[i][31] ? 31'(-e7[i]) : 31'(e7[i]);
        mm8[i] <= m7[i][32] ? 33'(-m7[i]) : 33'(m7[i]);
        sa8[i] <= a7[i][31] ^ na7[66];
        se8[i] <= e7[i][31] ^ nb7[66];
        sm8[i] <= m7[i][32];
      end
    end
  end

  // k9, k10: dA*NA, dB*NB, m*D per axis
  logic [rmt_pkg::PROD_W-1:0] pa [3], pe [3], pm [3];

  for (genvar i = 0; i < 3; i++) begin : g_axis
    rmt_mul u_mul_a (
      .clk (clk), .en (en),
      .x (rmt_pkg::MUL_W'(am8[i])), .y (nam8), .prod (pa[i])
    );
    rmt_mul u_mul_e (
      .clk (clk), .en (en),
      .x (rmt_pkg::MUL_W'(em8[i])), .y (nbm8), .prod (pe[i])
    );
    rmt_mul u_mul_m (
      .clk (clk), .en (en),
      .x (rmt_pkg::MUL_W'(mm8[i])), .y (rmt_pkg::MUL_W'(d8)), .prod (pm[i])
    );
  end

  logic        sa9 [3], se9 [3], sm9 [3], sa10 [3], se10 [3], sm10 [3];
  logic [60:0] d9, d10;
  logic        par9, par10;

  always_ff @(posedge clk) begin
    if (en) begin
      d9    <= d8;
      d10   <= d9;
      par9  <= par8;
      par10 <= par9;
      for (int i = 0; i < 3; i++) begin
        sa9[i]  <= sa8[i];
        se9[i]  <= se8[i];
        sm9[i]  <= sm8[i];
        sa10[i] <= sa9[i];
        se10[i] <= se9[i];
        sm10[i] <= sm9[i];
      end
    end
  end

  // k11: signed terms
  logic signed [rmt_pkg::T_W-1:0] ta11 [3], te11 [3], tm11 [3];
  logic [60:0] d11;
  logic        par11;

  always_ff @(posedge clk) begin
    if (en) begin
      d11   <= d10;
      par11 <= par10;
      for (int i = 0; i < 3; i++) begin
        ta11[i] <= sa10[i] ? -$signed({1'b0, pa[i][98:0]}) : $signed({1'b0, pa[i][98:0]});
        te11[i] <= se10[i] ? -$signed({1'b0, pe[i][98:0]}) : $signed({1'b0, pe[i][98:0]});
        tm11[i] <= sm10[i] ? -$signed({1'b0, pm[i][98:0]}) : $signed({1'b0, pm[i][98:0]});
      end
    end
  end

  // k12: T per axis, divisor 2*D
  always_ff @(posedge clk) begin
    if (en) begin
      dbl <= {d11, 1'b0};
      par <= par11;
      for (int i = 0; i < 3; i++) begin
        t[i] <= ta11[i] + te11[i] + tm11[i];
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rmt_div.sv
`timescale 1ns / 1ps
`default_nettype none

// pipelined restoring divider, one quotient bit per bit stage, rounded and saturated
module rmt_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [rmt_pkg::T_W-1:0] t,
  input  logic [rmt_pkg::DV_W-1:0]       dv,
  output rmt_pkg::fix32_t                point
);

  localparam int NB = rmt_pkg::DIV_BITS;

  // magnitude and sign
  logic [rmt_pkg::T_W-2:0]  tm13;
  logic                     tn13;
  logic [rmt_pkg::DV_W-1:0] d13;

  always_ff @(posedge clk) begin
    if (en) begin
      tm13 <= t[rmt_pkg::T_W-1] ? (rmt_pkg::T_W-1)'(-t) : (rmt_pkg::T_W-1)'(t);
      tn13 <= t[rmt_pkg::T_W-1];
      d13  <= dv;
    end
  end

  // quotient overflow check: result at least 2^33 saturates anyway
  logic [rmt_pkg::REM_W-1:0] rem_s [NB+1];
  logic [NB-1:0]             q_s   [NB+1];
  logic [rmt_pkg::DV_W-1:0]  d_s   [NB+1];
  logic                      tn_s  [NB+1];
  logic                      ovf_s [NB+1];

  logic [rmt_pkg::REM_W-1:0] rem14;
  logic [rmt_pkg::DV_W-1:0]  d14;
  logic                      tn14, ovf14;

  always_ff @(posedge clk) begin
    if (en) begin
      ovf14 <= tm13 >= ((rmt_pkg::T_W-1)'(d13) << NB);
      rem14 <= tm13[rmt_pkg::REM_W-1:0];
      d14   <= d13;
      tn14  <= tn13;
    end
  end

  assign rem_s[0] = rem14;
  assign q_s[0]   = '0;
  assign d_s[0]   = d14;
  assign tn_s[0]  = tn14;
  assign ovf_s[0] = ovf14;

  for (genvar j = 0; j < NB; j++) begin : g_bit
    logic [rmt_pkg::REM_W-1:0] dsh;
    logic                      take;
    logic [rmt_pkg::REM_W-1:0] rem_r;
    logic [NB-1:0]             q_r;
    logic [rmt_pkg::DV_W-1:0]  d_r;
    logic                      tn_r, ovf_r;

    assign dsh  = rmt_pkg::REM_W'(d_s[j]) << (NB - 1 - j);
    assign take = rem_s[j] >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= take ? rem_s[j] - dsh : rem_s[j];
        q_r   <= {q_s[j][NB-2:0], take};
        d_r   <= d_s[j];
        tn_r  <= tn_s[j];
        ovf_r <= ovf_s[j];
      end
    end

    assign rem_s[j+1] = rem_r;
    assign q_s[j+1]   = q_r;
    assign d_s[j+1]   = d_r;
    assign tn_s[j+1]  = tn_r;
    assign ovf_s[j+1] = ovf_r;
  end

  // round half away from zero, then saturate
  logic          rnd;
  logic [NB:0]   qr;

  assign rnd = {rem_s[NB], 1'b0} >= (rmt_pkg::REM_W + 1)'(d_s[NB]);
  assign qr  = {1'b0, q_s[NB]} + (NB + 1)'(rnd);

  always_ff @(posedge clk) begin
    if (en) begin
      if (tn_s[NB]) begin
        if (ovf_s[NB] || qr > (NB + 1)'(34'd2147483648)) begin
          point <= rmt_pkg::SAT_MIN;
        end else begin
          point <= -(qr[31:0]);
        end
      end else begin
        if (ovf_s[NB] || qr > (NB + 1)'(34'd2147483647)) begin
          point <= rmt_pkg::SAT_MAX;
        end else begin
          point <= qr[31:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rmt_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module rmt_chk (
  input logic            clk,
  input logic            rst,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input rmt_pkg::fix32_t point_x,
  input rmt_pkg::fix32_t point_y,
  input rmt_pkg::fix32_t point_z,
  input logic            point_valid
);

  // input back-pressure only ever comes from a held output beat
  a_ready_low_needs_out: assert property (
    @(posedge clk) disable iff (rst) !in_ready |-> out_valid
  ) else $error("in_ready low with no output beat pending");

  // nothing comes out straight after reset
  a_reset_quiet: assert property (
    @(posedge clk) rst |=> !out_valid
  ) else $error("output beat straight after reset");

  // parallel rays carry a zero point
  a_parallel_zero: assert property (
    @(posedge clk) disable iff (rst)
      out_valid && !point_valid |-> point_x == 0 && point_y == 0 && point_z == 0
  ) else $error("invalid point not zero");

  // a stalled output beat holds
  a_out_hold: assert property (
    @(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y)
        && $stable(point_z) && $stable(point_valid)
  ) else $error("output beat changed under stall");

endmodule

bind ray_midpoint_triangulation rmt_chk u_rmt_chk (.*);

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // wide signed working type for the midpoint arithmetic (Q.76 numerators etc)
  typedef logic signed [255:0] wide_t;

  typedef struct {
    rmt_pkg::fix32_t oa [3];
    rmt_pkg::fix32_t da [3];
    rmt_pkg::fix32_t ob [3];
    rmt_pkg::fix32_t db [3];
  } ray_pair_t;

  typedef struct {
    rmt_pkg::fix32_t x;
    rmt_pkg::fix32_t y;
    rmt_pkg::fix32_t z;
    logic            ok;
  } midpoint_t;

  typedef struct {
    ray_pair_t pr;
    bit        known;   // expected value typed in rather than predicted
    midpoint_t want;
  } vector_row_t;

  localparam int PHASES      = 6;
  localparam int PER_PHASE   = 275;
  localparam int CALM_TAIL   = 150;  // last beats of the run with no idling
  localparam int DRAIN_WAIT  = 60;   // longer than the pipe latency
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  rmt_pkg::fix32_t first_origin_x = '0, first_origin_y = '0, first_origin_z = '0;
  rmt_pkg::fix32_t first_dir_x = '0, first_dir_y = '0, first_dir_z = '0;
  rmt_pkg::fix32_t second_origin_x = '0, second_origin_y = '0, second_origin_z = '0;
  rmt_pkg::fix32_t second_dir_x = '0, second_dir_y = '0, second_dir_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rmt_pkg::fix32_t point_x, point_y, point_z;
  logic point_valid;
  logic cfg_we = 1'b0;
  logic [rmt_pkg::LIM_W-1:0] cfg_wdata = '0;

  // testbench copy of the parallel limit register
  logic [rmt_pkg::LIM_W-1:0] limit_shadow = rmt_pkg::LIMIT_RESET;

  midpoint_t   pending_points [$];
  vector_row_t directed_rows [$];
  int  mismatches = 0;
  int  beats_in = 0, beats_out = 0, parallel_seen = 0, saturated_seen = 0;
  int  quiet_cycles = 0;
  bit  calm = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ray_midpoint_triangulation dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_origin_x(first_origin_x), .first_origin_y(first_origin_y),
    .first_origin_z(first_origin_z),
    .first_dir_x(first_dir_x), .first_dir_y(first_dir_y), .first_dir_z(first_dir_z),
    .second_origin_x(second_origin_x), .second_origin_y(second_origin_y),
    .second_origin_z(second_origin_z),
    .second_dir_x(second_dir_x), .second_dir_y(second_dir_y),
    .second_dir_z(second_dir_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .point_valid(point_valid),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------
  // Midpoint predictor
  // ---------------------------------------------------------------------

  // direction components are held to [-1, 1] in Q1.30
  function automatic wide_t dir_clip(input rmt_pkg::fix32_t d);
    wide_t v;
    v = wide_t'(d);
    if (v > wide_t'(rmt_pkg::DIR_ONE)) v = wide_t'(rmt_pkg::DIR_ONE);
    if (v < -wide_t'(rmt_pkg::DIR_ONE)) v = -wide_t'(rmt_pkg::DIR_ONE);
    return v;
  endfunction

  // divide, rounding to nearest with ties away from zero
  function automatic wide_t div_nearest(input wide_t num, input wide_t d);
    wide_t mag, quo, rem;
    mag = (num < 0) ? -num : num;
    quo = mag / d;
    rem = mag - quo * d;
    if (rem >= d - rem) quo = quo + 1;
    return (num < 0) ? -quo : quo;
  endfunction

  function automatic rmt_pkg::fix32_t clip32(input wide_t v);
    if (v > wide_t'(rmt_pkg::SAT_MAX)) return rmt_pkg::SAT_MAX;
    if (v < wide_t'(rmt_pkg::SAT_MIN)) return rmt_pkg::SAT_MIN;
    return rmt_pkg::fix32_t'(v);
  endfunction

  function automatic midpoint_t predict_midpoint(input ray_pair_t r,
                                                 input logic [rmt_pkg::LIM_W-1:0] lim);
    wide_t a [3], e [3], b [3], m [3];
    wide_t one, cosang, u, den, p, q, na, nb, t;
    midpoint_t res;
    one = wide_t'(rmt_pkg::ONE_Q60);
    cosang = 0;
    p = 0;
    q = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = dir_clip(r.da[i]);
      e[i] = dir_clip(r.db[i]);
      b[i] = wide_t'(r.ob[i]) - wide_t'(r.oa[i]);
      m[i] = wide_t'(r.oa[i]) + wide_t'(r.ob[i]);
      cosang = cosang + a[i] * e[i];
    end
    // non-unit directions: keep |c| <= 1 so the denominator stays >= 0
    if (cosang > one) cosang = one;
    if (cosang < -one) cosang = -one;
    u = one - ((cosang < 0) ? -cosang : cosang);
    den = (u * (2 * one - u)) >>> 60;
    res = '{x: '0, y: '0, z: '0, ok: 1'b0};
    if (den == 0 || den < wide_t'({1'b0, lim})) return res;
    for (int i = 0; i < 3; i++) begin
      p = p + b[i] * a[i];
      q = q + b[i] * e[i];
    end
    na = p - div_nearest(q * cosang, one);
    nb = div_nearest(p * cosang, one) - q;
    t = na * a[0] + nb * e[0] + m[0] * den;
    res.x = clip32(div_nearest(t, 2 * den));
    t = na * a[1] + nb * e[1] + m[1] * den;
    res.y = clip32(div_nearest(t, 2 * den));
    t = na * a[2] + nb * e[2] + m[2] * den;
    res.z = clip32(div_nearest(t, 2 * den));
    res.ok = 1'b1;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic ray_pair_t mk_pair(
      input rmt_pkg::fix32_t oax, oay, oaz, dax, day, daz,
      input rmt_pkg::fix32_t obx, oby, obz, dbx, dby, dbz);
    ray_pair_t r;
    r.oa = '{oax, oay, oaz};
    r.da = '{dax, day, daz};
    r.ob = '{obx, oby, obz};
    r.db = '{dbx, dby, dbz};
    return r;
  endfunction

  task automatic add_row(input ray_pair_t pr, input bit known, input midpoint_t want);
    vector_row_t row;
    row.pr = pr;
    row.known = known;
    row.want = want;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic unit_dir(output rmt_pkg::fix32_t d [3]);
    real v [3];
    real n;
    n = 0.0;
    while (n < 1.0) begin
      for (int i = 0; i < 3; i++) v[i] = real'($urandom_range(0, 2000000)) - 1.0e6;
      n = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
    end
    for (int i = 0; i < 3; i++)
      d[i] = rmt_pkg::fix32_t'($rtoi(v[i] / n * 1073741823.0));
  endtask

  function automatic rmt_pkg::fix32_t rand_origin();
    if ($urandom_range(0, 3) == 0) return rmt_pkg::fix32_t'($urandom);
    return rmt_pkg::fix32_t'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
  endfunction

  task automatic rand_pair(output ray_pair_t r);
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      r.oa[i] = rand_origin();
      r.ob[i] = rand_origin();
    end
    unit_dir(r.da);
    if (kind == 0) begin
      // raw noise, out-of-range directions included
      for (int i = 0; i < 3; i++) begin
        r.oa[i] = rmt_pkg::fix32_t'($urandom);
        r.ob[i] = rmt_pkg::fix32_t'($urandom);
        r.da[i] = rmt_pkg::fix32_t'($urandom);
        r.db[i] = rmt_pkg::fix32_t'($urandom);
      end
    end else if (kind <= 3) begin
      // near-parallel pair, straddles the parallel limit
      for (int i = 0; i < 3; i++)
        r.db[i] = r.da[i]
                  + rmt_pkg::fix32_t'(int'($urandom_range(0, 1 << (2 * kind + 4)))
                  - (1 << (2 * kind + 3)));
    end else begin
      unit_dir(r.db);
    end
  endtask

  task automatic send_pair(input ray_pair_t r, input bit known, input midpoint_t want);
    midpoint_t exp_pt;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    {first_origin_x, first_origin_y, first_origin_z} = {r.oa[0], r.oa[1], r.oa[2]};
    {first_dir_x, first_dir_y, first_dir_z} = {r.da[0], r.da[1], r.da[2]};
    {second_origin_x, second_origin_y, second_origin_z} = {r.ob[0], r.ob[1], r.ob[2]};
    {second_dir_x, second_dir_y, second_dir_z} = {r.db[0], r.db[1], r.db[2]};
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    exp_pt = known ? want : predict_midpoint(r, limit_shadow);
    pending_points.insert(pending_points.size(), exp_pt);
    beats_in++;
    @(negedge clk);
  endtask

  // register writes only with the pipe empty
  task automatic write_limit(input logic [rmt_pkg::LIM_W-1:0] v);
    in_valid = 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_wdata = v;
    cfg_we = 1'b1;
    limit_shadow = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Sink side: random stalls, then result checking
  // ---------------------------------------------------------------------

  initial begin
    @(negedge clk);
    forever begin
      out_ready = 1'b1;
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    midpoint_t w;
    if (!rst && out_valid && out_ready) begin
      beats_out++;
      if (pending_points.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        w = pending_points.pop_front();
        if (point_x !== w.x) begin
          $error("point_x: expected %0d, got %0d", w.x, point_x);
          mismatches++;
        end
        if (point_y !== w.y) begin
          $error("point_y: expected %0d, got %0d", w.y, point_y);
          mismatches++;
        end
        if (point_z !== w.z) begin
          $error("point_z: expected %0d, got %0d", w.z, point_z);
          mismatches++;
        end
        if (point_valid !== w.ok) begin
          $error("point_valid: expected %0b, got %0b", w.ok, point_valid);
          mismatches++;
        end
        if (!w.ok) parallel_seen++;
        if (w.ok && (w.x == rmt_pkg::SAT_MAX || w.x == rmt_pkg::SAT_MIN))
          saturated_seen++;
      end
    end
  end

  // watchdog: no beat moving while work is outstanding
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (pending_points.size() == 0 && !in_valid))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin
    ray_pair_t rp;
    logic [rmt_pkg::LIM_W-1:0] lim_set [PHASES];
    midpoint_t zero_pt, org_pt;
    rmt_pkg::fix32_t M, N, D1;

    M = rmt_pkg::SAT_MAX;
    N = rmt_pkg::SAT_MIN;
    D1 = rmt_pkg::DIR_ONE;
    zero_pt = '{x: '0, y: '0, z: '0, ok: 1'b0};
    org_pt  = '{x: '0, y: '0, z: '0, ok: 1'b1};

    // zero directions: c = 0, full denominator, midpoint of origins
    add_row(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, org_pt);
    // perpendicular axes through the origin
    add_row(mk_pair(0, 0, 0, D1, 0, 0, 0, 0, 0, 0, D1, 0), 1, org_pt);
    // identical directions: parallel
    add_row(mk_pair(5, 6, 7, D1, 0, 0, 9, 9, 9, D1, 0, 0), 1, zero_pt);
    // opposite directions: parallel
    add_row(mk_pair(M, N, 0, 0, 0, -D1, N, M, 0, 0, 0, D1), 1, zero_pt);
    // out-of-range directions clip to +1 / -1, then parallel
    add_row(mk_pair(1, 2, 3, 32'sh7FFF_FFFF, 0, 0, 4, 5, 6,
                    32'sh8000_0000, 0, 0), 1, zero_pt);
    // non-unit directions: c clips to 1, parallel
    add_row(mk_pair(0, 0, 0, D1, D1, D1, 0, 0, 0, D1, D1, D1), 1, zero_pt);
    // lines meet at the extreme corners
    add_row(mk_pair(M, M, M, D1, 0, 0, M, M, M, 0, D1, 0), 1,
            '{x: M, y: M, z: M, ok: 1'b1});
    add_row(mk_pair(N, N, N, 0, 0, D1, N, N, N, 0, -D1, 0), 1,
            '{x: N, y: N, z: N, ok: 1'b1});
    // predicted: two small-angle far crossings that saturate, then wider angles
    add_row(mk_pair(0, 0, 0, D1, 0, 0, 0, M, 0, D1 - 1, 32768, 0), 0, zero_pt);
    add_row(mk_pair(0, 0, 0, -D1, 0, 0, 0, N, 0, 1 - D1, 32768, 0), 0, zero_pt);
    add_row(mk_pair(M, N, M, D1, 0, 0, N, M, N, 0, 0, D1), 0, zero_pt);
    add_row(mk_pair(N, M, N, 0, -D1, 0, M, N, M, -D1, 0, 0), 0, zero_pt);
    add_row(mk_pair(-1, -1, -1, 32'sh4000_0000, 32'sh0, 32'sh0,
                    -1, -1, -1, 32'sh2d41_3ccd, 32'sh2d41_3ccd, 0), 0, zero_pt);

    lim_set[0] = rmt_pkg::LIMIT_RESET;
    lim_set[1] = '0;
    lim_set[2] = 61'(rmt_pkg::ONE_Q60);
    lim_set[3] = 61'({$urandom, $urandom} % (64'(rmt_pkg::ONE_Q60) + 1));
    lim_set[4] = 61'd3000000000;
    lim_set[5] = rmt_pkg::LIMIT_RESET;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      send_pair(directed_rows[i].pr, directed_rows[i].known, directed_rows[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      // phase 0 runs on the reset value; the last phase writes it back
      if (ph > 0) write_limit(lim_set[ph]);
      for (int k = 0; k < PER_PHASE; k++) begin
        calm = (ph == PHASES - 1) && (k >= PER_PHASE - CALM_TAIL);
        rand_pair(rp);
        send_pair(rp, 0, zero_pt);
      end
    end
    in_valid = 1'b0;

    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("run: %0d ray pairs in, %0d points out over %0d limit settings",
             beats_in, beats_out, PHASES);
    $display("run: %0d flagged parallel, %0d saturated on x", parallel_seen,
             saturated_seen);
    if (mismatches == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/rmt_pkg.sv
hw/rtl/rmt_mul.sv
hw/rtl/rmt_geom.sv
hw/rtl/rmt_div.sv
hw/rtl/ray_midpoint_triangulation.sv
hw/rtl/rmt_chk.sv
tb/testbench.sv
